@@ rtl/smo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smo_pkg: shared types and constants for the sliding mode back-EMF observer
// Item structs, sequencer step codes, unit opcodes, register indexes, resets.
// ----------------------------------------------------------------------------
package smo_pkg;

   // Q16.16 one and its bounds for the switching decision
   localparam logic [16:0]        QOne     = 17'd65536;
   localparam logic signed [31:0] ErrHigh  = 32'sh0001_0000;
   localparam logic signed [31:0] ErrLow   = -32'sh0001_0000;

   // Register reset values
   localparam logic [30:0] ResetSamplePeriod = 31'd6;
   localparam logic [30:0] ResetResistance   = 31'd65536;
   localparam logic [30:0] ResetInvInduct    = 31'd65536;
   localparam logic [30:0] ResetGain         = 31'd65536;
   localparam logic [16:0] ResetFilterFactor = 17'd655;

   // Register indexes
   localparam logic [2:0] CSR_SAMPLE_PERIOD = 3'd0;
   localparam logic [2:0] CSR_RESISTANCE    = 3'd1;
   localparam logic [2:0] CSR_INV_INDUCT    = 3'd2;
   localparam logic [2:0] CSR_GAIN          = 3'd3;
   localparam logic [2:0] CSR_ALPHA_FACTOR  = 3'd4;
   localparam logic [2:0] CSR_BETA_FACTOR   = 3'd5;

   // Sequencer steps; ST_RL through ST_FB advance by one
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RL    = 4'd1;   // R * 1/L
   localparam logic [3:0] ST_DROP  = 4'd2;   // (R/L) * est
   localparam logic [3:0] ST_DIFF  = 4'd3;   // volt - emf
   localparam logic [3:0] ST_DRIVE = 4'd4;   // (volt - emf) * 1/L
   localparam logic [3:0] ST_SUB   = 4'd5;   // drive - drop
   localparam logic [3:0] ST_DELTA = 4'd6;   // Ts * (drive - drop)
   localparam logic [3:0] ST_EST   = 4'd7;   // est += delta
   localparam logic [3:0] ST_ERR   = 4'd8;   // est - meas
   localparam logic [3:0] ST_SW    = 4'd9;   // switching emf
   localparam logic [3:0] ST_FA    = 4'd10;  // emf * f
   localparam logic [3:0] ST_FB    = 4'd11;  // lpf * (1 - f)
   localparam logic [3:0] ST_LPF   = 4'd12;  // lpf = sum
   localparam logic [3:0] ST_OUT   = 4'd13;  // hand result to output register

   // Shared unit opcodes
   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_ADD = 2'd1;
   localparam logic [1:0] OP_SUB = 2'd2;
   localparam logic [1:0] OP_SAT = 2'd3;

   typedef struct packed {
      logic signed [31:0] volt_alpha;
      logic signed [31:0] volt_beta;
      logic signed [31:0] meas_current_alpha;
      logic signed [31:0] meas_current_beta;
   } req_type;

   typedef struct packed {
      logic signed [31:0] emf_alpha_filtered;
      logic signed [31:0] emf_beta_filtered;
      logic signed [31:0] est_current_alpha;
      logic signed [31:0] est_current_beta;
   } rsp_type;

   typedef struct packed {
      logic [3:0] step;
      logic       axis;      // 0 alpha, 1 beta
      logic [1:0] op;
      logic       load_out;
   } ctrl_type;

endpackage

@@ rtl/smo_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smo_alu: shared arithmetic unit
// Q16.16 multiply (floor shift, wrap), add, subtract and the saturating
// switching term; result is captured by the caller's registers.
// ----------------------------------------------------------------------------
module smo_alu (
   input  logic [1:0]         op,
   input  logic signed [31:0] opa,
   input  logic signed [31:0] opb,
   output logic signed [31:0] res
);

   logic signed [63:0] prod;

   // full product; bits 47:16 are the floor-shifted, wrapped Q16.16 result
   assign prod = 64'(opa) * 64'(opb);

   always_comb begin
      case (op)
         smo_pkg::OP_MUL: res = prod[47:16];
         smo_pkg::OP_ADD: res = opa + opb;
         smo_pkg::OP_SUB: res = opa - opb;
         smo_pkg::OP_SAT: begin
            // opa is the gain, opb the current error; magnitude one stays linear
            if (opb > smo_pkg::ErrHigh) res = opa;
            else if (opb < smo_pkg::ErrLow) res = -opa;
            else res = prod[47:16];
         end
         default: res = prod[47:16];
      endcase
   end

endmodule

@@ rtl/smo_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smo_seq: step sequencer
// Walks one item through the shared unit: the R/L product once, then eleven
// steps per axis, then waits for the output register to free up.
// ----------------------------------------------------------------------------
module smo_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                out_free,
   output logic                busy,
   output smo_pkg::ctrl_type   ctrl
);

   logic [3:0] step_ff, step_in;
   logic       axis_ff, axis_in;

   // next step
   always_comb begin
      step_in = step_ff;
      axis_in = axis_ff;
      case (step_ff)
         smo_pkg::ST_IDLE: begin
            if (req_valid) begin
               step_in = smo_pkg::ST_RL;
               axis_in = 1'b0;
            end
         end
         smo_pkg::ST_LPF: begin
            if (!axis_ff) begin
               axis_in = 1'b1;
               step_in = smo_pkg::ST_DROP;
            end else begin
               step_in = smo_pkg::ST_OUT;
            end
         end
         smo_pkg::ST_OUT: begin
            if (out_free) begin
               step_in = smo_pkg::ST_IDLE;
               axis_in = 1'b0;
            end
         end
         default: begin
            if (step_ff inside {[smo_pkg::ST_RL:smo_pkg::ST_FB]}) step_in = step_ff + 4'd1;
            else step_in = smo_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= smo_pkg::ST_IDLE;
         axis_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         axis_ff <= axis_in;
      end
   end

   // opcode per step
   always_comb begin
      ctrl.step     = step_ff;
      ctrl.axis     = axis_ff;
      ctrl.load_out = (step_ff == smo_pkg::ST_OUT) && out_free;
      case (step_ff)
         smo_pkg::ST_DIFF,
         smo_pkg::ST_SUB,
         smo_pkg::ST_ERR: ctrl.op = smo_pkg::OP_SUB;
         smo_pkg::ST_EST,
         smo_pkg::ST_LPF: ctrl.op = smo_pkg::OP_ADD;
         smo_pkg::ST_SW:  ctrl.op = smo_pkg::OP_SAT;
         default:         ctrl.op = smo_pkg::OP_MUL;
      endcase
   end

   assign busy = (step_ff != smo_pkg::ST_IDLE);

endmodule

@@ rtl/sliding_mode_back_emf_observer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_mode_back_emf_observer: alpha/beta back-EMF observer, Q16.16
// Forward-Euler current model, saturated switching term, first-order
// low-pass on the back-EMF; one result item per input item.
//
//   channel  ports                               direction  handshake
//   req      req_valid req_stall req_data        in         valid / stall
//   rsp      rsp_valid rsp_stall rsp_data        out        valid / stall
//   csr      csr_valid csr_ready csr_index/data  in         valid / ready
//
// From accept to the next possible accept, an item runs 23 operations
// through the single shared multiply/add unit (R/L once, eleven per axis),
// then the output step that loads the output register and the idle step
// in which the next item is taken.
// Reset is synchronous: registers return to defaults, estimates clear to zero.
// A stalled result holds the last step until the output register frees up;
// req_stall is high for the whole time an item is being worked on.
// ----------------------------------------------------------------------------
module sliding_mode_back_emf_observer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smo_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smo_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);

   smo_pkg::ctrl_type ctrl;
   logic              busy;
   logic              out_free;

   // configuration registers
   logic [30:0] ts_ff, res_ff, invl_ff, gain_ff;
   logic [16:0] fa_ff, fb_ff;

   // observer state
   logic signed [31:0] est_a_ff, est_b_ff, lpf_a_ff, lpf_b_ff;

   // working registers
   smo_pkg::req_type   req_ff;
   logic signed [31:0] rl_ff, acc_ff, tmp_ff;

   // output register
   logic               rsp_valid_ff;
   smo_pkg::rsp_type   rsp_data_ff;

   // operand selection
   logic signed [31:0] est_sel, lpf_sel, volt_sel, meas_sel;
   logic [16:0]        f_raw, f_clamp, f_comp;
   logic signed [31:0] opa, opb, alu_res;

   smo_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .busy      (busy),
      .ctrl      (ctrl)
   );

   smo_alu u_alu (
      .op  (ctrl.op),
      .opa (opa),
      .opb (opb),
      .res (alu_res)
   );

   assign req_stall = busy;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff   <= smo_pkg::ResetSamplePeriod;
         res_ff  <= smo_pkg::ResetResistance;
         invl_ff <= smo_pkg::ResetInvInduct;
         gain_ff <= smo_pkg::ResetGain;
         fa_ff   <= smo_pkg::ResetFilterFactor;
         fb_ff   <= smo_pkg::ResetFilterFactor;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            smo_pkg::CSR_SAMPLE_PERIOD: ts_ff   <= csr_data[30:0];
            smo_pkg::CSR_RESISTANCE:    res_ff  <= csr_data[30:0];
            smo_pkg::CSR_INV_INDUCT:    invl_ff <= csr_data[30:0];
            smo_pkg::CSR_GAIN:          gain_ff <= csr_data[30:0];
            smo_pkg::CSR_ALPHA_FACTOR:  fa_ff   <= csr_data[16:0];
            smo_pkg::CSR_BETA_FACTOR:   fb_ff   <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // per-axis views
   assign est_sel  = ctrl.axis ? est_b_ff : est_a_ff;
   assign lpf_sel  = ctrl.axis ? lpf_b_ff : lpf_a_ff;
   assign volt_sel = ctrl.axis ? req_ff.volt_beta : req_ff.volt_alpha;
   assign meas_sel = ctrl.axis ? req_ff.meas_current_beta : req_ff.meas_current_alpha;

   // filter weight limited to one, and its complement
   assign f_raw   = ctrl.axis ? fb_ff : fa_ff;
   assign f_clamp = (f_raw > smo_pkg::QOne) ? smo_pkg::QOne : f_raw;
   assign f_comp  = smo_pkg::QOne - f_clamp;

   // operands of the shared unit
   always_comb begin
      case (ctrl.step)
         smo_pkg::ST_RL: begin
            opa = {1'b0, res_ff};
            opb = {1'b0, invl_ff};
         end
         smo_pkg::ST_DROP: begin
            opa = rl_ff;
            opb = est_sel;
         end
         smo_pkg::ST_DIFF: begin
            opa = volt_sel;
            opb = lpf_sel;
         end
         smo_pkg::ST_DRIVE: begin
            opa = tmp_ff;
            opb = {1'b0, invl_ff};
         end
         smo_pkg::ST_SUB: begin
            opa = tmp_ff;
            opb = acc_ff;
         end
         smo_pkg::ST_DELTA: begin
            opa = {1'b0, ts_ff};
            opb = tmp_ff;
         end
         smo_pkg::ST_EST: begin
            opa = est_sel;
            opb = tmp_ff;
         end
         smo_pkg::ST_ERR: begin
            opa = est_sel;
            opb = meas_sel;
         end
         smo_pkg::ST_SW: begin
            opa = {1'b0, gain_ff};
            opb = tmp_ff;
         end
         smo_pkg::ST_FA: begin
            opa = tmp_ff;
            opb = {15'd0, f_clamp};
         end
         smo_pkg::ST_FB: begin
            opa = lpf_sel;
            opb = {15'd0, f_comp};
         end
         smo_pkg::ST_LPF: begin
            opa = acc_ff;
            opb = tmp_ff;
         end
         default: begin
            opa = tmp_ff;
            opb = acc_ff;
         end
      endcase
   end

   // observer state write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         est_a_ff <= '0;
         est_b_ff <= '0;
         lpf_a_ff <= '0;
         lpf_b_ff <= '0;
      end else begin
         if (ctrl.step == smo_pkg::ST_EST) begin
            if (ctrl.axis) est_b_ff <= alu_res;
            else est_a_ff <= alu_res;
         end
         if (ctrl.step == smo_pkg::ST_LPF) begin
            if (ctrl.axis) lpf_b_ff <= alu_res;
            else lpf_a_ff <= alu_res;
         end
      end
   end

   // input capture and intermediate results
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) req_ff <= req_data;
      case (ctrl.step)
         smo_pkg::ST_RL: rl_ff <= alu_res;
         smo_pkg::ST_DROP,
         smo_pkg::ST_FA: acc_ff <= alu_res;
         smo_pkg::ST_DIFF,
         smo_pkg::ST_DRIVE,
         smo_pkg::ST_SUB,
         smo_pkg::ST_DELTA,
         smo_pkg::ST_ERR,
         smo_pkg::ST_SW,
         smo_pkg::ST_FB: tmp_ff <= alu_res;
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         rsp_data_ff.emf_alpha_filtered <= lpf_a_ff;
         rsp_data_ff.emf_beta_filtered  <= lpf_b_ff;
         rsp_data_ff.est_current_alpha  <= est_a_ff;
         rsp_data_ff.est_current_beta   <= est_b_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result appears only out of the final step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.step == smo_pkg::ST_OUT))
      else $error("result raised outside the output step");

   // an accepted item starts with the R/L product on the alpha axis
   a_start_step: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (ctrl.step == smo_pkg::ST_RL && !ctrl.axis))
      else $error("accepted item did not start the sequence");

   // the beta pass never covers the shared R/L step or idle
   a_axis_steps: assert property (@(posedge clock) disable iff (reset)
      ctrl.axis |-> (ctrl.step != smo_pkg::ST_RL && ctrl.step != smo_pkg::ST_IDLE))
      else $error("beta axis flag outside the per-axis steps");

   // no new result loads while an unaccepted one is held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !ctrl.load_out)
      else $error("held result overwritten");

endmodule

@@ test/emf_observer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emf_observer_checker: result predictor and comparator for the back-EMF observer
// Watches the sample, result and register channels at the clock edge, keeps
// its own copy of the register file, current estimates and filtered back-EMF,
// queues the result each accepted sample must produce, and compares every
// accepted result field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module emf_observer_checker
   import smo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          error_count,
   output int          pending_count
);

   // Shadow register file
   logic [30:0] step_time;
   logic [30:0] stator_res;
   logic [30:0] inv_induct;
   logic [30:0] slide_gain;
   logic [16:0] alpha_factor;
   logic [16:0] beta_factor;

   // Shadow observer state
   logic [31:0] est_alpha;
   logic [31:0] est_beta;
   logic [31:0] emf_alpha;
   logic [31:0] emf_beta;

   rsp_type predicted_estimates[$];

   // Q16.16 product: exact 64-bit product, floor shift by 16, wrap to 32 bits
   function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] prod;
      prod = 64'($signed(a)) * 64'($signed(b));
      return prod[47:16];
   endfunction

   // One forward-Euler step of the current model on one axis
   function automatic logic [31:0] euler_current(input logic [31:0] est,
                                                 input logic [31:0] volt,
                                                 input logic [31:0] emf);
      logic [31:0] r_over_l;
      logic [31:0] drop;
      logic [31:0] drive;
      r_over_l = fx_mul({1'b0, stator_res}, {1'b0, inv_induct});
      drop     = fx_mul(r_over_l, est);
      drive    = fx_mul(volt - emf, {1'b0, inv_induct});
      return est + fx_mul({1'b0, step_time}, drive - drop);
   endfunction

   // Switching back-EMF: linear inside +/-1 (boundary included), clipped outside
   function automatic logic [31:0] switching_term(input logic [31:0] est,
                                                  input logic [31:0] meas);
      logic signed [31:0] err;
      err = est - meas;
      if (err > ErrHigh)
         return {1'b0, slide_gain};
      else if (err < ErrLow)
         return 32'd0 - {1'b0, slide_gain};
      else
         return fx_mul(err, {1'b0, slide_gain});
   endfunction

   // First-order low pass; a weight above one acts as one
   function automatic logic [31:0] emf_filter(input logic [31:0] prev,
                                              input logic [31:0] sample,
                                              input logic [16:0] factor);
      logic [31:0] weight;
      weight = (factor > QOne) ? 32'(QOne) : 32'(factor);
      return fx_mul(sample, weight) + fx_mul(prev, 32'(QOne) - weight);
   endfunction

   task automatic predict_sample(input req_type s);
      rsp_type r;
      est_alpha = euler_current(est_alpha, s.volt_alpha, emf_alpha);
      est_beta  = euler_current(est_beta, s.volt_beta, emf_beta);
      emf_alpha = emf_filter(emf_alpha, switching_term(est_alpha, s.meas_current_alpha),
                             alpha_factor);
      emf_beta  = emf_filter(emf_beta, switching_term(est_beta, s.meas_current_beta),
                             beta_factor);
      r.emf_alpha_filtered = emf_alpha;
      r.emf_beta_filtered  = emf_beta;
      r.est_current_alpha  = est_alpha;
      r.est_current_beta   = est_beta;
      predicted_estimates.push_back(r);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", field, want, got);
         error_count++;
      end
   endtask

   // Channel monitor: results first, then register writes, then new samples
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         step_time    = ResetSamplePeriod;
         stator_res   = ResetResistance;
         inv_induct   = ResetInvInduct;
         slide_gain   = ResetGain;
         alpha_factor = ResetFilterFactor;
         beta_factor  = ResetFilterFactor;
         est_alpha    = '0;
         est_beta     = '0;
         emf_alpha    = '0;
         emf_beta     = '0;
         error_count  = 0;
         predicted_estimates.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_estimates.size() == 0) begin
               $error("result item with no sample outstanding: %h", rsp_data);
               error_count++;
            end else begin
               want = predicted_estimates.pop_front();
               check_field("emf_alpha_filtered", want.emf_alpha_filtered,
                           rsp_data.emf_alpha_filtered);
               check_field("emf_beta_filtered", want.emf_beta_filtered,
                           rsp_data.emf_beta_filtered);
               check_field("est_current_alpha", want.est_current_alpha,
                           rsp_data.est_current_alpha);
               check_field("est_current_beta", want.est_current_beta,
                           rsp_data.est_current_beta);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_PERIOD: step_time    = csr_data[30:0];
               CSR_RESISTANCE:    stator_res   = csr_data[30:0];
               CSR_INV_INDUCT:    inv_induct   = csr_data[30:0];
               CSR_GAIN:          slide_gain   = csr_data[30:0];
               CSR_ALPHA_FACTOR:  alpha_factor = csr_data[16:0];
               CSR_BETA_FACTOR:   beta_factor  = csr_data[16:0];
               default: ;  // unmapped index, write dropped
            endcase
         end
         if (req_valid && !req_stall)
            predict_sample(req_data);
      end
      pending_count <= predicted_estimates.size();
   end

endmodule

@@ test/sliding_mode_back_emf_observer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_mode_back_emf_observer_tb: stimulus and verdict for the observer
// Runs a short directed set (field extremes, current error on and around the
// +/-1 switching boundary per axis, clamped filter weight, unmapped register
// writes), then phases of random samples under typical, maximum, zero and
// random register settings. Samples go out in bursts with random gaps; the
// result side stalls in changing patterns. Checking lives in the checker.
// ----------------------------------------------------------------------------
module sliding_mode_back_emf_observer_tb;
   import smo_pkg::*;

   localparam int SamplesPerPhase = 60;
   localparam int PhaseCount      = 8;
   localparam logic [2:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CSR_SPARE_HIGH = 3'd7;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_e;
   typedef enum int {CFG_TYPICAL, CFG_MAX, CFG_ZERO, CFG_WILD} cfg_profile_e;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   int          error_count;
   int          pending_count;

   rsp_type     last_result;
   int          burst_left = 0;
   stall_mode_e stall_mode = STALL_NONE;
   int          stall_timer = 0;
   int          stall_run = 0;

   sliding_mode_back_emf_observer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   emf_observer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Latest accepted estimates, used to aim measured currents near the estimate
   always @(posedge clock) begin
      if (reset)
         last_result <= '0;
      else if (rsp_valid && !rsp_stall)
         last_result <= rsp_data;
   end

   // Result-side stall: the pattern is redrawn whenever its timer runs out
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= stall_mode_e'($urandom_range(0, 3));
         stall_timer <= $urandom_range(50, 300);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_run == 0) begin
               rsp_stall <= ~rsp_stall;
               stall_run <= $urandom_range(1, 40);
            end else begin
               stall_run <= stall_run - 1;
            end
         end
      endcase
   end

   // Send one sample and wait for it to be taken; valid drops only at a gap
   task automatic send_sample(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 8)) @(posedge clock);
         else
            repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Register write; valid is left high for back-to-back writes
   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Full register set, plus a poke at an unmapped index that must be dropped
   task automatic program_regs(input logic [31:0] ts, input logic [31:0] res,
                               input logic [31:0] inv_l, input logic [31:0] gain,
                               input logic [31:0] fa, input logic [31:0] fb);
      write_reg(CSR_SAMPLE_PERIOD, ts);
      write_reg(CSR_RESISTANCE, res);
      write_reg(CSR_INV_INDUCT, inv_l);
      write_reg(CSR_GAIN, gain);
      write_reg(CSR_ALPHA_FACTOR, fa);
      write_reg(CSR_BETA_FACTOR, fb);
      write_reg($urandom_range(0, 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic program_profile(input cfg_profile_e profile);
      case (profile)
         CFG_TYPICAL:
            program_regs($urandom_range(1, 700), $urandom_range(0, 3 << 16),
                         $urandom_range(1 << 16, 400 << 16), $urandom_range(0, 40 << 16),
                         $urandom_range(0, 65536), $urandom_range(0, 65536));
         CFG_MAX:
            program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'd65536, 32'h0001_FFFF);
         CFG_ZERO:
            program_regs('0, '0, '0, '0, '0, '0);
         default:
            program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
   endtask

   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 6))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return 32'h0001_0000;
         5:       return 32'hFFFF_0000;
         default: return 32'h0001_0001;
      endcase
   endfunction

   // Mostly plausible drive with currents within +/-1.5 of the estimate
   function automatic req_type next_sample();
      req_type s;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         s.volt_alpha         = $urandom_range(0, 96 << 16) - (48 << 16);
         s.volt_beta          = $urandom_range(0, 96 << 16) - (48 << 16);
         s.meas_current_alpha = last_result.est_current_alpha
                                + $urandom_range(0, 3 << 16) - (3 << 15);
         s.meas_current_beta  = last_result.est_current_beta
                                + $urandom_range(0, 3 << 16) - (3 << 15);
      end else if (pick < 85) begin
         s = {$urandom, $urandom, $urandom, $urandom};
      end else begin
         s = {corner_word(), corner_word(), corner_word(), corner_word()};
      end
      return s;
   endfunction

   // Run limit
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      // current error offsets (alpha, beta) around the switching boundary
      int err_offsets[8][2] = '{
         '{65536, -65536}, '{-65536, 65536}, '{65537, -65537}, '{-65537, 65537},
         '{65535, 0}, '{0, -65535}, '{6553600, 1}, '{-1, -6553600}};
      cfg_profile_e phase_plan[PhaseCount] = '{
         CFG_TYPICAL, CFG_MAX, CFG_TYPICAL, CFG_WILD,
         CFG_ZERO, CFG_TYPICAL, CFG_WILD, CFG_TYPICAL};
      req_type s;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_SAMPLE_PERIOD;
      csr_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset register values: zero sample and field extremes
      send_sample('0);
      send_sample({32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
      send_sample({32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
      send_sample({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      wait_drained();

      // Zero step freezes the estimates, so the current error is set exactly.
      // Alpha weight above one (clamped), beta weight exactly one.
      program_regs('0, 32'd65536, 32'd65536, 32'h7FFF_FFFF, 32'h0001_FFFF, 32'd65536);
      foreach (err_offsets[i]) begin
         s.volt_alpha         = $urandom;
         s.volt_beta          = $urandom;
         s.meas_current_alpha = last_result.est_current_alpha - err_offsets[i][0];
         s.meas_current_beta  = last_result.est_current_beta - err_offsets[i][1];
         send_sample(s);
      end
      send_sample({32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF});
      send_sample({32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000});

      // Random phases, each under its own register setting
      for (int ph = 0; ph < PhaseCount; ph++) begin
         wait_drained();
         program_profile(phase_plan[ph]);
         for (int n = 0; n < SamplesPerPhase; n++)
            send_sample(next_sample());
      end

      wait_drained();
      repeat (30) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
